/* sv/spi_pkg.sv */
// shared types and constants for the segment plane intersect block
`timescale 1ns / 1ps
package spi_pkg;
    localparam int FracBits = 17;
    localparam int MagBits  = 32;
    localparam int DivSteps = 17;

    localparam logic [1:0] SIDE_ON    = 2'd0;
    localparam logic [1:0] SIDE_ABOVE = 2'd1;
    localparam logic [1:0] SIDE_BELOW = 2'd2;

    // register indexes
    localparam logic [2:0] REG_NORMAL_X  = 3'd0;
    localparam logic [2:0] REG_NORMAL_Y  = 3'd1;
    localparam logic [2:0] REG_NORMAL_Z  = 3'd2;
    localparam logic [2:0] REG_OFFSET    = 3'd3;
    localparam logic [2:0] REG_NEAR_ZERO = 3'd4;

    // word carried through the divider cells
    typedef struct packed {
        logic signed [31:0] start_distance;
        logic signed [31:0] end_distance;
        logic [1:0]         start_side;
        logic [1:0]         end_side;
        logic               crosses;
    } t_info;

    typedef struct packed {
        logic [MagBits:0]   rem;
        logic [MagBits:0]   den;
        logic [MagBits-1:0] num;
        logic [FracBits-1:0] quo;
    } t_div;
endpackage

/* sv/spi_seg_if.sv */
// valid/ready channel carrying one segment word
`timescale 1ns / 1ps
interface spi_seg_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
    modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                    input ready);
    modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  output ready);
endinterface

// valid/ready channel carrying one result word
interface spi_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] start_distance;
    logic signed [31:0] end_distance;
    logic [1:0]         start_side;
    logic [1:0]         end_side;
    logic               crosses;
    logic [16:0]        fraction;
    modport source (output valid, start_distance, end_distance, start_side, end_side,
                    crosses, fraction, input ready);
    modport sink (input valid, start_distance, end_distance, start_side, end_side,
                  crosses, fraction, output ready);
endinterface

/* sv/spi_div_cell.sv */
// one restoring division step cell, passing its word to the next cell
`timescale 1ns / 1ps
module spi_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  spi_pkg::t_div  i_div,
    input  spi_pkg::t_info i_info,
    output logic           o_valid,
    output spi_pkg::t_div  o_div,
    output spi_pkg::t_info o_info
);
    logic                  r_valid;
    spi_pkg::t_div         r_div;
    spi_pkg::t_info        r_info;
    spi_pkg::t_div         n_div;
    logic [spi_pkg::MagBits+1:0] w_trial;

    // shift in next numerator bit and try a subtract
    always_comb begin
        n_div       = i_div;
        w_trial     = {i_div.rem, i_div.num[spi_pkg::MagBits-1]} - {1'b0, i_div.den};
        n_div.num   = {i_div.num[spi_pkg::MagBits-2:0], 1'b0};
        if (!w_trial[spi_pkg::MagBits+1]) begin
            n_div.rem = w_trial[spi_pkg::MagBits:0];
            n_div.quo = {i_div.quo[spi_pkg::FracBits-2:0], 1'b1};
        end else begin
            n_div.rem = {i_div.rem[spi_pkg::MagBits-1:0], i_div.num[spi_pkg::MagBits-1]};
            n_div.quo = {i_div.quo[spi_pkg::FracBits-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div  <= n_div;
            r_info <= i_info;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;
    assign o_info  = r_info;
endmodule

/* sv/spi_dist.sv */
// plane distance pipeline: products, sum and saturate, side and crossing
`timescale 1ns / 1ps
module spi_dist (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [31:0] i_start_x,
    input  logic signed [31:0] i_start_y,
    input  logic signed [31:0] i_start_z,
    input  logic signed [31:0] i_end_x,
    input  logic signed [31:0] i_end_y,
    input  logic signed [31:0] i_end_z,
    input  logic signed [15:0] i_nx,
    input  logic signed [15:0] i_ny,
    input  logic signed [15:0] i_nz,
    input  logic signed [31:0] i_offset,
    input  logic [15:0]        i_limit,
    output logic               o_valid,
    output spi_pkg::t_info     o_info,
    output spi_pkg::t_div      o_div
);
    logic                     r_v1;
    logic signed [47:0]       r_p [6];
    logic signed [49:0]       w_ss;
    logic signed [49:0]       w_se;
    logic signed [36:0]       w_ds;
    logic signed [36:0]       w_de;
    logic signed [31:0]       w_sat_s;
    logic signed [31:0]       w_sat_e;
    logic [32:0]              w_as;
    logic [32:0]              w_ae;
    logic                     w_cross;
    spi_pkg::t_info           n_info;
    spi_pkg::t_div            n_div;

    function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
        if (v > 37'sd2147483647) return 32'sh7fffffff;
        if (v < -37'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic [32:0] mag33(input logic signed [31:0] v);
        logic [32:0] e;
        e = {v[31], v};
        return v[31] ? (~e + 33'd1) : e;
    endfunction

    function automatic logic [1:0] side(input logic signed [31:0] v,
                                        input logic [32:0] m, input logic [15:0] lim);
        if (m <= {17'd0, lim}) return spi_pkg::SIDE_ON;
        return v[31] ? spi_pkg::SIDE_BELOW : spi_pkg::SIDE_ABOVE;
    endfunction

    // stage one: six products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= i_nx * i_start_x;
            r_p[1] <= i_ny * i_start_y;
            r_p[2] <= i_nz * i_start_z;
            r_p[3] <= i_nx * i_end_x;
            r_p[4] <= i_ny * i_end_y;
            r_p[5] <= i_nz * i_end_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v1    <= i_valid;
            o_valid <= r_v1;
        end
    end

    // stage two: sum, floor shift, offset, saturate and classify
    always_comb begin
        w_ss    = 50'(r_p[0]) + 50'(r_p[1]) + 50'(r_p[2]);
        w_se    = 50'(r_p[3]) + 50'(r_p[4]) + 50'(r_p[5]);
        w_ds    = 37'(w_ss >>> 14) - 37'(i_offset);
        w_de    = 37'(w_se >>> 14) - 37'(i_offset);
        w_sat_s = sat32(w_ds);
        w_sat_e = sat32(w_de);
        w_as    = mag33(w_sat_s);
        w_ae    = mag33(w_sat_e);
        w_cross = !((w_sat_s > 0 && w_sat_e > 0) || (w_sat_s < 0 && w_sat_e < 0));
        n_info.start_distance = w_sat_s;
        n_info.end_distance   = w_sat_e;
        n_info.start_side     = side(w_sat_s, w_as, i_limit);
        n_info.end_side       = side(w_sat_e, w_ae, i_limit);
        n_info.crosses        = w_cross;
        // numerator is |ds| * 2^16; all but its low 17 bits seed the remainder
        n_div.den = w_as + w_ae;
        n_div.rem = {1'b0, w_as[32:1]};
        n_div.num = {w_as[0], 31'd0};
        n_div.quo = '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_info <= n_info;
            o_div  <= n_div;
        end
    end
endmodule

/* sv/segment_plane_intersect_core.sv */
// top level: config registers, distance pipeline, divider cell chain, output
// register; an accepted word passes 2 distance stages, 17 divide cells and
// 1 output register; throughput one segment per cycle unless the output is held
// the 17 cell divider chain is the longest part; a stall holds the whole pipe
// synchronous active-low reset clears valids and loads register reset values
`timescale 1ns / 1ps
module segment_plane_intersect_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    spi_seg_if.sink     i_seg,
    spi_res_if.source   o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int N = spi_pkg::DivSteps;

    logic signed [15:0] r_nx, r_ny, r_nz;
    logic signed [31:0] r_offset;
    logic [15:0]        r_limit;
    logic               w_en;
    logic               w_dv;
    spi_pkg::t_info     w_dinfo;
    spi_pkg::t_div      w_ddiv;
    logic               w_cv   [N+1];
    spi_pkg::t_info     w_cinfo[N+1];
    spi_pkg::t_div      w_cdiv [N+1];
    logic [2:0]         w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];

    // config write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nx     <= 16'sd0;
            r_ny     <= 16'sd0;
            r_nz     <= 16'sd16384;
            r_offset <= 32'sd0;
            r_limit  <= 16'd66;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                spi_pkg::REG_NORMAL_X:  r_nx     <= pwdata[15:0];
                spi_pkg::REG_NORMAL_Y:  r_ny     <= pwdata[15:0];
                spi_pkg::REG_NORMAL_Z:  r_nz     <= pwdata[15:0];
                spi_pkg::REG_OFFSET:    r_offset <= pwdata;
                spi_pkg::REG_NEAR_ZERO: r_limit  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // config read
    always_comb begin
        unique case (w_idx)
            spi_pkg::REG_NORMAL_X:  prdata = {{16{r_nx[15]}}, r_nx};
            spi_pkg::REG_NORMAL_Y:  prdata = {{16{r_ny[15]}}, r_ny};
            spi_pkg::REG_NORMAL_Z:  prdata = {{16{r_nz[15]}}, r_nz};
            spi_pkg::REG_OFFSET:    prdata = r_offset;
            spi_pkg::REG_NEAR_ZERO: prdata = {16'd0, r_limit};
            default:                prdata = '0;
        endcase
    end

    // pipe advances unless the output word is held
    assign w_en        = !o_res.valid || o_res.ready;
    assign i_seg.ready = w_en;

    spi_dist u_dist (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(i_seg.valid),
        .i_start_x(i_seg.start_x), .i_start_y(i_seg.start_y), .i_start_z(i_seg.start_z),
        .i_end_x(i_seg.end_x), .i_end_y(i_seg.end_y), .i_end_z(i_seg.end_z),
        .i_nx(r_nx), .i_ny(r_ny), .i_nz(r_nz), .i_offset(r_offset), .i_limit(r_limit),
        .o_valid(w_dv), .o_info(w_dinfo), .o_div(w_ddiv)
    );

    assign w_cv[0]    = w_dv;
    assign w_cinfo[0] = w_dinfo;
    assign w_cdiv[0]  = w_ddiv;

    // divider cell chain, one quotient bit per cell
    for (genvar g = 0; g < N; g++) begin : g_cell
        spi_div_cell u_cell (
            .i_clk, .i_rst_n, .i_en(w_en),
            .i_valid(w_cv[g]), .i_div(w_cdiv[g]), .i_info(w_cinfo[g]),
            .o_valid(w_cv[g+1]), .o_div(w_cdiv[g+1]), .o_info(w_cinfo[g+1])
        );
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_res.valid <= 1'b0;
        end else if (w_en) begin
            o_res.valid <= w_cv[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_res.start_distance <= w_cinfo[N].start_distance;
            o_res.end_distance   <= w_cinfo[N].end_distance;
            o_res.start_side     <= w_cinfo[N].start_side;
            o_res.end_side       <= w_cinfo[N].end_side;
            o_res.crosses        <= w_cinfo[N].crosses;
            o_res.fraction       <= (w_cinfo[N].crosses && w_cdiv[N].den != '0)
                                    ? w_cdiv[N].quo : '0;
        end
    end
endmodule

/* sv/spi_checker.sv */
// port-level checks for the segment plane intersect core
`timescale 1ns / 1ps
module spi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  start_side,
    input logic [1:0]  end_side,
    input logic        crosses,
    input logic [16:0] fraction,
    input logic signed [31:0] start_distance
);
    a_frac_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !crosses |-> fraction == 17'd0) else $error("fraction without crossing");
    a_frac_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> fraction <= 17'd65536) else $error("fraction out of range");
    a_side_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> start_side <= spi_pkg::SIDE_BELOW && end_side <= spi_pkg::SIDE_BELOW)
        else $error("bad side");
    a_front_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && start_side == spi_pkg::SIDE_ABOVE |-> start_distance > 0)
        else $error("front sign");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule

bind segment_plane_intersect_core spi_checker u_spi_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .out_valid(o_res.valid), .out_ready(o_res.ready),
    .start_side(o_res.start_side), .end_side(o_res.end_side),
    .crosses(o_res.crosses), .fraction(o_res.fraction),
    .start_distance(o_res.start_distance)
);

/* tb/sv/tb.sv */
// testbench for the segment plane intersect core: table-driven directed words, then random words
`timescale 1ns / 1ps
module tb;
    typedef struct packed {
        logic signed [31:0] sx, sy, sz, ex, ey, ez;
    } t_seg;

    typedef struct packed {
        logic signed [31:0] ds, de;
        logic [1:0]         ss, es;
        logic               cr;
        logic [16:0]        fr;
    } t_hit;

    // directed row: segment, and a typed-in expectation where obvious
    typedef struct packed {
        t_seg seg;
        logic known;
        t_hit hit;
    } t_row;

    localparam int Latency = 20;
    localparam int WatchLimit = 5000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    spi_seg_if seg_bus ();
    spi_res_if res_bus ();

    segment_plane_intersect_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_seg(seg_bus.sink), .o_res(res_bus.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    // plane copy held by the predictor
    logic signed [15:0] pl_nx = 16'sd0, pl_ny = 16'sd0, pl_nz = 16'sd16384;
    logic signed [31:0] pl_off = 32'sd0;
    logic [15:0] pl_band = 16'd66;

    t_hit hits_due[$];
    int errors = 0;
    int idle_cycles = 0;
    bit sending_done = 1'b0;
    bit hold_off = 1'b0;

    initial begin
        seg_bus.valid = 1'b0;
        seg_bus.start_x = '0; seg_bus.start_y = '0; seg_bus.start_z = '0;
        seg_bus.end_x = '0; seg_bus.end_y = '0; seg_bus.end_z = '0;
        res_bus.ready = 1'b0;
    end

    // signed distance of one point, floored to Q16.16 and saturated
    function automatic logic signed [31:0] point_dist(logic signed [31:0] px,
            logic signed [31:0] py, logic signed [31:0] pz);
        logic signed [63:0] acc;
        logic signed [63:0] d;
        acc = 64'(pl_nx) * 64'(px) + 64'(pl_ny) * 64'(py) + 64'(pl_nz) * 64'(pz);
        d = (acc >>> 14) - 64'(pl_off);
        if (d > 64'sd2147483647) d = 64'sd2147483647;
        if (d < -64'sd2147483648) d = -64'sd2147483648;
        return d[31:0];
    endfunction

    function automatic logic [1:0] side_for(logic signed [31:0] d);
        logic [32:0] m;
        m = d < 0 ? 33'(-64'(d)) : 33'(d);
        if (m <= 33'(pl_band)) return spi_pkg::SIDE_ON;
        return d > 0 ? spi_pkg::SIDE_ABOVE : spi_pkg::SIDE_BELOW;
    endfunction

    function automatic t_hit segment_hit(t_seg s);
        t_hit h;
        logic [32:0] as, ae;
        logic [49:0] num;
        logic same;
        h.ds = point_dist(s.sx, s.sy, s.sz);
        h.de = point_dist(s.ex, s.ey, s.ez);
        h.ss = side_for(h.ds);
        h.es = side_for(h.de);
        same = (h.ds > 0 && h.de > 0) || (h.ds < 0 && h.de < 0);
        h.cr = !same;
        h.fr = '0;
        if (!same) begin
            as = h.ds < 0 ? 33'(-64'(h.ds)) : 33'(h.ds);
            ae = h.de < 0 ? 33'(-64'(h.de)) : 33'(h.de);
            num = 50'(as) << 16;
            if (as + ae != 0) h.fr = 17'(num / 50'(34'(as) + 34'(ae)));
        end
        return h;
    endfunction

    // apb write: setup then access cycle, bus left selected for the next access
    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            spi_pkg::REG_NORMAL_X:  pl_nx = val[15:0];
            spi_pkg::REG_NORMAL_Y:  pl_ny = val[15:0];
            spi_pkg::REG_NORMAL_Z:  pl_nz = val[15:0];
            spi_pkg::REG_OFFSET:    pl_off = val;
            spi_pkg::REG_NEAR_ZERO: pl_band = val[15:0];
            default: ;
        endcase
    endtask

    // apb read: setup then access cycle, compare the returned value
    task automatic reg_check(logic [2:0] idx, logic [31:0] want);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== want) begin
            errors++;
            if (errors <= 10)
                $display("register %0d read: exp %h got %h", idx, want, prdata);
        end
    endtask

    task automatic set_plane(logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
            logic [31:0] off, logic [15:0] band);
        reg_write(spi_pkg::REG_NORMAL_X, {16'd0, nx});
        reg_write(spi_pkg::REG_NORMAL_Y, {16'd0, ny});
        reg_write(spi_pkg::REG_NORMAL_Z, {16'd0, nz});
        reg_write(spi_pkg::REG_OFFSET, off);
        reg_write(spi_pkg::REG_NEAR_ZERO, {16'd0, band});
        reg_check(spi_pkg::REG_NORMAL_X, {{16{pl_nx[15]}}, pl_nx});
        reg_check(spi_pkg::REG_NORMAL_Y, {{16{pl_ny[15]}}, pl_ny});
        reg_check(spi_pkg::REG_NORMAL_Z, {{16{pl_nz[15]}}, pl_nz});
        reg_check(spi_pkg::REG_OFFSET, pl_off);
        reg_check(spi_pkg::REG_NEAR_ZERO, {16'd0, pl_band});
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // drive one segment word after a random gap; valid stays up for a back-to-back word
    task automatic send_seg(t_seg s, int gap);
        if (gap != 0) begin
            seg_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        seg_bus.valid <= 1'b1;
        {seg_bus.start_x, seg_bus.start_y, seg_bus.start_z,
         seg_bus.end_x, seg_bus.end_y, seg_bus.end_z} <= s;
        @(posedge i_clk);
        while (!seg_bus.ready) @(posedge i_clk);
    endtask

    task automatic queue_and_send(t_seg s, logic known, t_hit typed);
        t_hit h;
        h = segment_hit(s);
        if (known && h != typed) begin
            errors++;
            if (errors <= 10)
                $display("directed row mismatch in predictor: typed %h model %h", typed, h);
        end
        hits_due.push_back(known ? typed : h);
        send_seg(s, $urandom_range(0, 7));
    endtask

    task automatic drain();
        seg_bus.valid <= 1'b0;
        while (hits_due.size() != 0) @(posedge i_clk);
        repeat (Latency + 5) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rnd_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 2047) - 1024;
            2: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
            default: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
        endcase
    endfunction

    function automatic t_seg rnd_seg();
        t_seg s;
        int mode;
        mode = $urandom_range(0, 9) < 6 ? 2 : $urandom_range(0, 3);
        s.sx = rnd_coord(mode); s.sy = rnd_coord(mode); s.sz = rnd_coord(mode);
        s.ex = rnd_coord(mode); s.ey = rnd_coord(mode); s.ez = rnd_coord(mode);
        // often mirror the end through the origin so the segment tends to straddle planes near it
        if ($urandom_range(0, 2) == 0) begin
            s.ex = -s.sx; s.ey = -s.sy; s.ez = -s.sz + 32'($urandom_range(0, 255));
        end
        return s;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_hit got, want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            got = '{res_bus.start_distance, res_bus.end_distance, res_bus.start_side,
                    res_bus.end_side, res_bus.crosses, res_bus.fraction};
            if (hits_due.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word %h", got);
            end else begin
                want = hits_due.pop_front();
                if (got != want) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: exp ds=%0d de=%0d ss=%0d es=%0d cr=%0d fr=%0d",
                                  " got ds=%0d de=%0d ss=%0d es=%0d cr=%0d fr=%0d"},
                            want.ds, want.de, want.ss, want.es, want.cr, want.fr,
                            got.ds, got.de, got.ss, got.es, got.cr, got.fr);
                end
            end
        end
    end

    // receiver stalls, with a long hold-off on request
    initial begin
        int wait_n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off) begin
                res_bus.ready <= 1'b0;
                repeat (200) @(posedge i_clk);
                hold_off = 1'b0;
            end
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (wait_n != 0) begin
                res_bus.ready <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
            end
            res_bus.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // watchdog on cycles with no accepted word
    always @(posedge i_clk) begin
        if ((seg_bus.valid && seg_bus.ready) || (res_bus.valid && res_bus.ready)
                || !i_rst_n || psel || (sending_done && hits_due.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchLimit) begin
            $display("FAIL");
            $finish;
        end
    end

    t_row rows[$];

    initial begin
        t_hit z;
        int n;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values read back
        reg_check(spi_pkg::REG_NORMAL_X, 32'd0);
        reg_check(spi_pkg::REG_NORMAL_Y, 32'd0);
        reg_check(spi_pkg::REG_NORMAL_Z, 32'd16384);
        reg_check(spi_pkg::REG_OFFSET, 32'd0);
        reg_check(spi_pkg::REG_NEAR_ZERO, 32'd66);
        psel <= 1'b0; penable <= 1'b0;
        @(posedge i_clk);

        // reset plane is z = 0 with band 66
        z = '0;
        rows.push_back('{'0, 1'b1, '{0, 0, spi_pkg::SIDE_ON, spi_pkg::SIDE_ON, 1'b1, 17'd0}});
        rows.push_back('{'{0, 0, 32'sh10000, 0, 0, -32'sh10000}, 1'b1,
            '{32'sh10000, -32'sh10000, spi_pkg::SIDE_ABOVE, spi_pkg::SIDE_BELOW,
              1'b1, 17'd32768}});
        rows.push_back('{'{0, 0, 32'sh10000, 0, 0, 0}, 1'b1,
            '{32'sh10000, 0, spi_pkg::SIDE_ABOVE, spi_pkg::SIDE_ON, 1'b1, 17'd65536}});
        rows.push_back('{'{0, 0, 32'sh10000, 0, 0, 32'sh20000}, 1'b1,
            '{32'sh10000, 32'sh20000, spi_pkg::SIDE_ABOVE, spi_pkg::SIDE_ABOVE,
              1'b0, 17'd0}});
        rows.push_back('{'{0, 0, 66, 0, 0, -67}, 1'b1,
            '{66, -67, spi_pkg::SIDE_ON, spi_pkg::SIDE_BELOW, 1'b1, 17'd32521}});
        rows.push_back('{'{0, 0, -5, 0, 0, -6}, 1'b1,
            '{-5, -6, spi_pkg::SIDE_ON, spi_pkg::SIDE_ON, 1'b0, 17'd0}});
        rows.push_back('{'{32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
            32'h80000000, 32'h80000000, 32'h80000000}, 1'b1,
            '{32'h7fffffff, 32'h80000000, spi_pkg::SIDE_ABOVE, spi_pkg::SIDE_BELOW,
              1'b1, 17'd32767}});
        rows.push_back('{'{-1, -1, -1, 1, 1, 1}, 1'b0, z});
        rows.push_back('{'{32'h55555555, 32'haaaaaaaa, 32'h0000ffff,
            32'haaaaaaaa, 32'h55555555, 32'hffff0000}, 1'b0, z});
        foreach (rows[i]) queue_and_send(rows[i].seg, rows[i].known, rows[i].hit);
        drain();

        // extremes of the registers: saturation both ways, widest band
        set_plane(16'h7fff, 16'h7fff, 16'h7fff, 32'h80000000, 16'hffff);
        queue_and_send('{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0}, 1'b0, z);
        queue_and_send('{0, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000}, 1'b0, z);
        queue_and_send('{0, 0, 100, 0, 0, -100}, 1'b0, z);
        drain();
        set_plane(16'h8000, 16'h8000, 16'h8000, 32'h7fffffff, 16'h0000);
        queue_and_send('{32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
            32'h80000000, 32'h80000000, 32'h80000000}, 1'b0, z);
        queue_and_send('{0, 0, 0, 1, 1, 1}, 1'b0, z);
        drain();

        // random phases, each under a fresh plane
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 5) set_plane(16'h0000, 16'h0000, 16'h4000, 32'h0, 16'd66);
            else set_plane(16'($urandom), 16'($urandom), 16'($urandom),
                (ph % 2) ? $urandom : 32'($urandom_range(0, 65535) - 32768),
                $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 200)));
            n = 320;
            for (int k = 0; k < n; k++) begin
                if (ph == 2 && k == 40) hold_off = 1'b1;
                queue_and_send(rnd_seg(), 1'b0, z);
            end
            drain();
        end
        sending_done = 1'b1;

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
